@@ hdl/stereo_one_pole_band_filter_top_assert.svh @@
// assertion macros for the band filter checker
`ifndef STEREO_ONE_POLE_BAND_FILTER_TOP_ASSERT_SVH
`define STEREO_ONE_POLE_BAND_FILTER_TOP_ASSERT_SVH

// same-cycle implication on clk, off during reset
`define SOPBF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on clk, off during reset
`define SOPBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/sopbf_pkg.sv @@
// types, constants and helper functions of the band filter
package sopbf_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int CHANNELS    = 2;
    localparam int STATE_W     = 32;
    localparam int EXTRA_BITS  = STATE_W - SAMPLE_BITS;
    localparam int CH_BITS     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SEC_BITS    = CH_BITS + 1;
    localparam int SEC_DEPTH   = 2 ** SEC_BITS;

    localparam int ALPHA_W     = 19;
    localparam int ALPHA_FRAC  = 18;
    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC   = 12;
    localparam int GAIN_SHIFT  = GAIN_FRAC + EXTRA_BITS;

    localparam int WIDE_W      = STATE_W + 1;
    localparam int MUL_B_W     = ALPHA_W + 1;
    localparam int PROD_W      = WIDE_W + MUL_B_W;
    localparam int NS_W        = STATE_W + 4;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = ALPHA_W;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE    = ALPHA_W'(1) << ALPHA_FRAC;
    localparam logic [GAIN_W-1:0]  GAIN_DEFAULT = GAIN_W'(1) << GAIN_FRAC;

    localparam logic signed [PROD_W-1:0] ALPHA_RND = PROD_W'(1) << (ALPHA_FRAC - 1);
    localparam logic signed [PROD_W-1:0] GAIN_RND  = PROD_W'(1) << (GAIN_SHIFT - 1);
    localparam logic signed [WIDE_W:0]   OUT_RND   = (WIDE_W + 1)'(1) << (EXTRA_BITS - 1);

    localparam logic signed [NS_W-1:0] STATE_HI = (NS_W'(1) << (STATE_W - 1)) - NS_W'(1);
    localparam logic signed [NS_W-1:0] STATE_LO = -(NS_W'(1) << (STATE_W - 1));
    localparam logic signed [NS_W-1:0] SAMPLE_HI = (NS_W'(1) << (SAMPLE_BITS - 1)) - NS_W'(1);
    localparam logic signed [NS_W-1:0] SAMPLE_LO = -(NS_W'(1) << (SAMPLE_BITS - 1));

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [STATE_W-1:0]     state_val_t;
    typedef logic signed [WIDE_W-1:0]      wide_t;
    typedef logic signed [MUL_B_W-1:0]     mul_b_t;
    typedef logic signed [PROD_W-1:0]      prod_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FIRST_ALPHA,
        REG_SECOND_ALPHA,
        REG_FIRST_HP,
        REG_SECOND_HP,
        REG_BAND_GAIN
    } cfg_reg_t;

    typedef struct packed {
        logic [ALPHA_W-1:0] first_alpha;
        logic [ALPHA_W-1:0] second_alpha;
        logic               first_highpass;
        logic               second_highpass;
        logic [GAIN_W-1:0]  band_gain;
    } cfg_t;

    typedef struct packed {
        logic   en;
        wide_t  a;
        mul_b_t b;
    } mul_req_t;

    function automatic state_val_t clamp_state(input logic signed [NS_W-1:0] v);
        state_val_t r;
        if (v > STATE_HI)
            r = STATE_HI[STATE_W-1:0];
        else if (v < STATE_LO)
            r = STATE_LO[STATE_W-1:0];
        else
            r = v[STATE_W-1:0];
        return r;
    endfunction

    function automatic sample_t sat_sample(input logic signed [NS_W-1:0] v);
        sample_t r;
        if (v > SAMPLE_HI)
            r = SAMPLE_HI[SAMPLE_BITS-1:0];
        else if (v < SAMPLE_LO)
            r = SAMPLE_LO[SAMPLE_BITS-1:0];
        else
            r = v[SAMPLE_BITS-1:0];
        return r;
    endfunction

endpackage

@@ hdl/sopbf_in_if.sv @@
// input frame channel
interface sopbf_in_if;
    import sopbf_pkg::*;

    logic    valid;
    logic    ready;
    sample_t left_sample;
    sample_t right_sample;
    logic    clear_state;
    logic    block_end;

    modport source (output valid, left_sample, right_sample, clear_state, block_end,
                    input ready);
    modport sink   (input valid, left_sample, right_sample, clear_state, block_end,
                    output ready);
endinterface

@@ hdl/sopbf_out_if.sv @@
// result frame channel
interface sopbf_out_if;
    import sopbf_pkg::*;

    logic    valid;
    logic    ready;
    sample_t left_out;
    sample_t right_out;
    logic    end_of_block;

    modport source (output valid, left_out, right_out, end_of_block, input ready);
    modport sink   (input valid, left_out, right_out, end_of_block, output ready);
endinterface

@@ hdl/sopbf_cfg_if.sv @@
// configuration write channel
interface sopbf_cfg_if;
    import sopbf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/sopbf_cfg_regs.sv @@
// configuration register file with alpha limiting
module sopbf_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    sopbf_cfg_if.sink          cfg,
    output sopbf_pkg::cfg_t    cfg_out
);
    import sopbf_pkg::*;

    logic [ALPHA_W-1:0] first_alpha_reg, first_alpha_next;
    logic [ALPHA_W-1:0] second_alpha_reg, second_alpha_next;
    logic               first_hp_reg, first_hp_next;
    logic               second_hp_reg, second_hp_next;
    logic [GAIN_W-1:0]  band_gain_reg, band_gain_next;
    logic               wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;

    always_comb
    begin
        first_alpha_next  = first_alpha_reg;
        second_alpha_next = second_alpha_reg;
        first_hp_next     = first_hp_reg;
        second_hp_next    = second_hp_reg;
        band_gain_next    = band_gain_reg;
        if (wr_en)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_FIRST_ALPHA:  first_alpha_next  = cfg.data[ALPHA_W-1:0];
                REG_SECOND_ALPHA: second_alpha_next = cfg.data[ALPHA_W-1:0];
                REG_FIRST_HP:     first_hp_next     = cfg.data[0];
                REG_SECOND_HP:    second_hp_next    = cfg.data[0];
                REG_BAND_GAIN:    band_gain_next    = cfg.data[GAIN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_alpha_reg  <= ALPHA_ONE;
            second_alpha_reg <= ALPHA_ONE;
            first_hp_reg     <= 1'b0;
            second_hp_reg    <= 1'b0;
            band_gain_reg    <= GAIN_DEFAULT;
        end
        else
        begin
            first_alpha_reg  <= first_alpha_next;
            second_alpha_reg <= second_alpha_next;
            first_hp_reg     <= first_hp_next;
            second_hp_reg    <= second_hp_next;
            band_gain_reg    <= band_gain_next;
        end
    end

    // alpha coefficients above one act as one
    always_comb
    begin
        cfg_out.first_alpha     = (first_alpha_reg > ALPHA_ONE) ? ALPHA_ONE : first_alpha_reg;
        cfg_out.second_alpha    = (second_alpha_reg > ALPHA_ONE) ? ALPHA_ONE
                                                                 : second_alpha_reg;
        cfg_out.first_highpass  = first_hp_reg;
        cfg_out.second_highpass = second_hp_reg;
        cfg_out.band_gain       = band_gain_reg;
    end
endmodule

@@ hdl/sopbf_mul.sv @@
// shared signed multiplier with registered product
module sopbf_mul (
    input  logic                clk,
    input  sopbf_pkg::mul_req_t req,
    output sopbf_pkg::prod_t    prod
);
    import sopbf_pkg::*;

    prod_t prod_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
            prod_reg <= PROD_W'(req.a) * PROD_W'(req.b);
    end

    assign prod = prod_reg;
endmodule

@@ hdl/sopbf_seq.sv @@
// sequencer, section state and result register of the band filter
module sopbf_seq (
    input  logic                clk,
    input  logic                rst_n,
    sopbf_in_if.sink            in_ch,
    sopbf_out_if.source         out_ch,
    input  sopbf_pkg::cfg_t     cfg,
    output sopbf_pkg::mul_req_t mul_req,
    input  sopbf_pkg::prod_t    prod
);
    import sopbf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF1,
        ST_MUL1,
        ST_UPD1,
        ST_GAIN,
        ST_MID,
        ST_MUL2,
        ST_UPD2,
        ST_EMIT
    } state_t;

    state_t               state_reg;
    logic [CH_BITS-1:0]   ch_reg;
    sample_t              sample_reg [CHANNELS];
    sample_t              res_reg [CHANNELS];
    logic                 end_reg;
    state_val_t           x_reg;
    wide_t                d_reg;
    wide_t                y_reg;
    state_val_t           sec_state_reg [SEC_DEPTH];
    logic                 out_valid_reg;
    sample_t              out_left_reg;
    sample_t              out_right_reg;
    logic                 out_end_reg;

    logic                 in_acc;
    logic                 second_sec;
    logic [SEC_BITS-1:0]  sec_idx;
    state_val_t           s_cur;
    state_val_t           x_in;
    prod_t                prod_alpha;
    logic signed [PROD_W-ALPHA_FRAC-1:0] rnd_alpha;
    logic signed [NS_W-1:0] ns_sum;
    state_val_t           ns;
    logic                 hp;
    wide_t                y_new;
    prod_t                prod_gain;
    logic signed [PROD_W-GAIN_SHIFT-1:0] rnd_gain;
    sample_t              mid;
    state_val_t           x2;
    logic signed [WIDE_W:0] fin_sum;
    logic signed [WIDE_W-EXTRA_BITS:0] fin_rnd;
    sample_t              res_new;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.left_out     = out_left_reg;
    assign out_ch.right_out    = out_right_reg;
    assign out_ch.end_of_block = out_end_reg;

    // section datapath
    always_comb
    begin
        second_sec = (state_reg == ST_MID) || (state_reg == ST_MUL2)
                     || (state_reg == ST_UPD2);
        sec_idx    = {second_sec, ch_reg};
        s_cur      = sec_state_reg[sec_idx];
        x_in       = {sample_reg[ch_reg], {EXTRA_BITS{1'b0}}};

        prod_alpha = prod + ALPHA_RND;
        rnd_alpha  = prod_alpha[PROD_W-1:ALPHA_FRAC];
        ns_sum     = NS_W'(s_cur) + NS_W'(rnd_alpha);
        ns         = clamp_state(ns_sum);
        hp         = second_sec ? cfg.second_highpass : cfg.first_highpass;
        y_new      = hp ? (WIDE_W'(x_reg) - WIDE_W'(ns)) : WIDE_W'(ns);

        prod_gain  = prod + GAIN_RND;
        rnd_gain   = prod_gain[PROD_W-1:GAIN_SHIFT];
        mid        = sat_sample(NS_W'(rnd_gain));
        x2         = {mid, {EXTRA_BITS{1'b0}}};

        fin_sum    = (WIDE_W + 1)'(y_new) + OUT_RND;
        fin_rnd    = fin_sum[WIDE_W:EXTRA_BITS];
        res_new    = sat_sample(NS_W'(fin_rnd));
    end

    // multiplier requests
    always_comb
    begin
        mul_req.en = (state_reg == ST_MUL1) || (state_reg == ST_GAIN)
                     || (state_reg == ST_MUL2);
        mul_req.a  = (state_reg == ST_GAIN) ? y_reg : d_reg;
        if (state_reg == ST_GAIN)
            mul_req.b = $signed({{(MUL_B_W - GAIN_W){1'b0}}, cfg.band_gain});
        else if (state_reg == ST_MUL2)
            mul_req.b = $signed({1'b0, cfg.second_alpha});
        else
            mul_req.b = $signed({1'b0, cfg.first_alpha});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= '0;
            end_reg       <= 1'b0;
            x_reg         <= '0;
            d_reg         <= '0;
            y_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_left_reg  <= '0;
            out_right_reg <= '0;
            out_end_reg   <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                sample_reg[i] <= '0;
                res_reg[i]    <= '0;
            end
            for (int i = 0; i < SEC_DEPTH; i++)
                sec_state_reg[i] <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready && (state_reg != ST_EMIT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (in_ch.clear_state)
                        begin
                            for (int i = 0; i < SEC_DEPTH; i++)
                                sec_state_reg[i] <= '0;
                        end
                        else
                        begin
                            sample_reg[0] <= in_ch.left_sample;
                            if (CHANNELS > 1)
                                sample_reg[CHANNELS-1] <= in_ch.right_sample;
                            end_reg   <= in_ch.block_end;
                            ch_reg    <= '0;
                            state_reg <= ST_DIFF1;
                        end
                    end
                end
                ST_DIFF1:
                begin
                    x_reg     <= x_in;
                    d_reg     <= WIDE_W'(x_in) - WIDE_W'(s_cur);
                    state_reg <= ST_MUL1;
                end
                ST_MUL1:
                    state_reg <= ST_UPD1;
                ST_UPD1:
                begin
                    sec_state_reg[sec_idx] <= ns;
                    y_reg     <= y_new;
                    state_reg <= ST_GAIN;
                end
                ST_GAIN:
                    state_reg <= ST_MID;
                ST_MID:
                begin
                    x_reg     <= x2;
                    d_reg     <= WIDE_W'(x2) - WIDE_W'(s_cur);
                    state_reg <= ST_MUL2;
                end
                ST_MUL2:
                    state_reg <= ST_UPD2;
                ST_UPD2:
                begin
                    sec_state_reg[sec_idx] <= ns;
                    res_reg[ch_reg]        <= res_new;
                    if (ch_reg == CH_BITS'(CHANNELS - 1))
                        state_reg <= ST_EMIT;
                    else
                    begin
                        ch_reg    <= ch_reg + 1'b1;
                        state_reg <= ST_DIFF1;
                    end
                end
                ST_EMIT:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_left_reg  <= res_reg[0];
                        out_right_reg <= (CHANNELS > 1) ? res_reg[CHANNELS-1] : '0;
                        out_end_reg   <= end_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

@@ hdl/stereo_one_pole_band_filter_top.sv @@
// top level of the stereo two-section one-pole band filter
//
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   left_sample, right_sample, clear_state, block_end
//  out_ch   out  valid/ready   left_out, right_out, end_of_block
//  cfg      in   valid/ready   index, data (always ready)
//
// a frame's result is loaded after both channels have passed through the section states,
// each channel using the shared multiplier for alpha, gain and alpha; the next frame
// is taken the cycle after the result is loaded
// a clear item leaves the sequencer idle and gives no result
// reset clears the section state and loads the default coefficients
// a stalled result holds the output register; the sequencer waits only if a new
// result is ready before the old one is taken
module stereo_one_pole_band_filter_top (
    input logic         clk,
    input logic         rst_n,
    sopbf_in_if.sink    in_ch,
    sopbf_out_if.source out_ch,
    sopbf_cfg_if.sink   cfg
);
    import sopbf_pkg::*;

    cfg_t     cfg_val;
    mul_req_t mul_req;
    prod_t    prod;

    sopbf_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_val)
    );

    sopbf_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    sopbf_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg     (cfg_val),
        .mul_req (mul_req),
        .prod    (prod)
    );
endmodule

@@ hdl/sopbf_checker.sv @@
// port-level checker for the band filter and its bind
`include "stereo_one_pole_band_filter_top_assert.svh"

module sopbf_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_clear,
    input logic out_valid,
    input logic out_ready,
    input logic [sopbf_pkg::SAMPLE_BITS-1:0] out_left,
    input logic [sopbf_pkg::SAMPLE_BITS-1:0] out_right,
    input logic out_end
);
    `SOPBF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `SOPBF_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_left) && $stable(out_right) && $stable(out_end), "result changed while stalled")
    `SOPBF_ASSERT_NEXT(a_busy_after_frame, in_valid && in_ready && !in_clear, !in_ready, "frame accepted without going busy")
    `SOPBF_ASSERT_NEXT(a_clear_quick, in_valid && in_ready && in_clear, in_ready, "clear item did not finish in one cycle")
    `SOPBF_ASSERT_SAME(a_result_from_busy, $rose(out_valid), !$past(in_ready), "result appeared while idle")
endmodule

bind stereo_one_pole_band_filter_top sopbf_checker u_sopbf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_clear  (in_ch.clear_state),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_left  (out_ch.left_out),
    .out_right (out_ch.right_out),
    .out_end   (out_ch.end_of_block)
);
